// File: rtl/rrhb_pkg.sv
// Shared types and constants of the rolling row history buffer.
// Used by rrhb_front, rrhb_back and rolling_row_history_buffer; no dependencies.
package rrhb_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned COLS       = 4;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned AW         = 6;   // row address
  localparam int unsigned CW         = 7;   // row count, 0..DEPTH
  localparam int unsigned ROW_WIDTH  = COLS * ELEM_WIDTH;
  localparam int unsigned TOT_WIDTH  = 38;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_SUM    = 3'd4;
  localparam logic [2:0] CMD_FLUSH  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [6:0] NOT_FOUND = 7'h7F;

  // Decoded request as it sits in the queue.
  typedef struct packed {
    logic [2:0]           op;
    logic [6:0]           sel;
    logic                 full_row;
    logic [1:0]           col;
    logic [ROW_WIDTH-1:0] row;       // zero past elem_count
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [6:0]           found;
    logic [ROW_WIDTH-1:0] row;
    logic [TOT_WIDTH-1:0] total;
    logic [CW-1:0]        row_count;
  } res_t;

endpackage

// File: rtl/rolling_row_history_buffer.sv
// Top level of the rolling row history buffer.
// Depends on rrhb_pkg, rrhb_front and rrhb_back.
//
// Requests enter on s_axis_*, one result per request leaves on m_axis_*.
// drop_at is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while the block is idle, which the block does not enforce. A request is decoded
// and queued (two entries), then the sequencer runs it against a 64-row store with
// one write and one registered read per cycle. Append, flush and error results are
// registered at once; a read result first passes the registered store read. Find
// and column sum scan the held rows, one row per cycle. One append, flush or error
// request is taken per cycle while m_axis_tready is high; no request is taken
// while a read, find or sum runs. Delete and the drop after an append report at
// once, then move the rows above down at one row per cycle before the next request
// starts. After a drop_at write the row count residue is rebuilt by subtraction
// before the next request. Reset empties the store (row count zero) and clears
// drop_at; no clearing pass is needed. A stalled m_axis_tready holds the result;
// the queue keeps taking requests until it is full.
module rolling_row_history_buffer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,     // drop_at
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command, row_select, elem_count, elem0..elem3, column, zero pad
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, found_index, out_elem0..out_elem3, column_total, row_count, zero pad
  output logic [183:0] m_axis_tdata
);

  logic           req_valid, req_ready;
  rrhb_pkg::req_t req;
  rrhb_pkg::res_t res;

  rrhb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  rrhb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.row_count, res.total, res.row, res.found, res.status};

endmodule

// File: rtl/rrhb_front.sv
// Front end: accepts stream requests, decodes them and queues them (two entries).
// Depends on rrhb_pkg.
module rrhb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [143:0]  s_axis_tdata,
  output logic          req_valid_o,
  input  logic          req_ready_i,
  output rrhb_pkg::req_t req_o
);

  rrhb_pkg::req_t dec;
  rrhb_pkg::req_t fifo_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic [2:0]     ecnt;
  logic           push, pop;

  assign ecnt = s_axis_tdata[12:10];

  always_comb begin
    dec.op       = s_axis_tdata[2:0];
    dec.sel      = s_axis_tdata[9:3];
    dec.full_row = (ecnt == 3'(rrhb_pkg::COLS));
    dec.col      = s_axis_tdata[142:141];
    for (int k = 0; k < 4; k++) begin
      dec.row[k*32 +: 32] = (3'(k) < ecnt) ? s_axis_tdata[13 + k*32 +: 32] : 32'd0;
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign req_valid_o   = (cnt_q != 2'd0);
  assign req_o         = fifo_q[rptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= dec;
  end

endmodule

// File: rtl/rrhb_back.sv
// Back end: row store, row count and the sequencer that carries out requests.
// Depends on rrhb_pkg.
module rrhb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rrhb_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output rrhb_pkg::res_t res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;

  localparam int unsigned RW = rrhb_pkg::ROW_WIDTH;
  localparam int unsigned TW = rrhb_pkg::TOT_WIDTH;
  localparam int unsigned CW = rrhb_pkg::CW;
  localparam int unsigned AW = rrhb_pkg::AW;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] held_q, held_d, mod_q, mod_d, drop_q;
  logic          dirty_q, dirty_d;
  logic [2:0]    op_q, op_d;
  logic [RW-1:0] row_q, row_d;
  logic [1:0]    col_q, col_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d, rd_left_q, rd_left_d;
  logic [CW-1:0] wr_ptr_q, wr_ptr_d, wr_left_q, wr_left_d;
  logic          rv_q, rv_d;
  logic [TW-1:0] total_q, total_d;
  logic          out_valid_q, out_valid_d;
  rrhb_pkg::res_t out_q, out_d;

  logic [RW-1:0] mem_q [rrhb_pkg::DEPTH];
  logic [RW-1:0] rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [RW-1:0] mem_wdata;

  logic          pop;
  logic [7:0]    sel8, idx8;
  logic [1:0]    rs_status;
  logic [CW-1:0] held_inc, mod_inc, mod_dec, half, cnt_tail;
  logic          trig;
  logic [31:0]   elem;
  logic [TW-1:0] tsum;

  assign req_ready_o = (state_q == S_IDLE) && !dirty_q && (!out_valid_q || res_ready_i);
  assign pop         = req_valid_i && req_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Resolve a row select; negative counts back from the newest row.
  assign sel8 = {req_i.sel[6], req_i.sel};
  assign idx8 = req_i.sel[6] ? ({1'b0, held_q} + sel8) : sel8;
  always_comb begin
    if (held_q == '0) begin
      rs_status = rrhb_pkg::ST_EMPTY;
    end else if (idx8[7] || (idx8 >= {1'b0, held_q})) begin
      rs_status = rrhb_pkg::ST_RANGE;
    end else begin
      rs_status = rrhb_pkg::ST_OK;
    end
  end

  assign held_inc = held_q + 1'b1;
  assign mod_inc  = ((mod_q + 1'b1) == drop_q) ? '0 : mod_q + 1'b1;
  assign mod_dec  = (mod_q == '0) ? drop_q - 1'b1 : mod_q - 1'b1;
  assign half     = drop_q >> 1;
  assign trig     = (drop_q != '0) && (mod_inc == '0) && (half != '0);
  assign cnt_tail = held_q - 1'b1 - idx8[CW-1:0];
  assign elem     = rdata_q[{col_q, 5'b0} +: 32];
  assign tsum     = total_q + {{(TW-32){elem[31]}}, elem};

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    mod_d       = mod_q;
    dirty_d     = dirty_q;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    rd_ptr_d    = rd_ptr_q;
    rd_left_d   = rd_left_q;
    wr_ptr_d    = wr_ptr_q;
    wr_left_d   = wr_left_q;
    rv_d        = 1'b0;
    total_d     = total_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = rd_ptr_q[AW-1:0];
    mem_waddr   = held_q[AW-1:0];
    mem_wdata   = req_i.row;

    case (state_q)
      S_IDLE: begin
        if (dirty_q) begin
          state_d = S_MOD;
          mod_d   = held_q;
          dirty_d = 1'b0;
        end else if (pop) begin
          op_d        = req_i.op;
          row_d       = req_i.row;
          col_d       = req_i.col;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.row_count = held_q;
          case (req_i.op)
            rrhb_pkg::CMD_APPEND: begin
              if (held_q == CW'(rrhb_pkg::DEPTH)) begin
                out_d.status = rrhb_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                if (trig) begin
                  held_d    = held_inc - half;
                  mod_d     = drop_q - half;
                  rd_ptr_d  = half;
                  rd_left_d = held_inc - half;
                  wr_ptr_d  = '0;
                  wr_left_d = held_inc - half;
                  state_d   = S_SHIFT;
                end else begin
                  held_d = held_inc;
                  if (drop_q != '0) mod_d = mod_inc;
                end
                out_d.row_count = held_d;
              end
            end
            rrhb_pkg::CMD_READ: begin
              if (rs_status == rrhb_pkg::ST_OK) begin
                out_valid_d = out_valid_q && !res_ready_i;
                out_d       = out_q;
                mem_re      = 1'b1;
                mem_raddr   = idx8[AW-1:0];
                state_d     = S_READ;
              end else begin
                out_d.status = rs_status;
              end
            end
            rrhb_pkg::CMD_DELETE: begin
              if (rs_status == rrhb_pkg::ST_OK) begin
                held_d = held_q - 1'b1;
                if (drop_q != '0) mod_d = mod_dec;
                rd_ptr_d  = idx8[CW-1:0] + 1'b1;
                rd_left_d = cnt_tail;
                wr_ptr_d  = idx8[CW-1:0];
                wr_left_d = cnt_tail;
                if (cnt_tail != '0) state_d = S_SHIFT;
                out_d.row_count = held_q - 1'b1;
              end else begin
                out_d.status = rs_status;
              end
            end
            rrhb_pkg::CMD_FIND: begin
              out_d.found = rrhb_pkg::NOT_FOUND;
              if (held_q == '0) begin
                out_d.status = rrhb_pkg::ST_EMPTY;
              end else if (req_i.full_row) begin
                out_valid_d = out_valid_q && !res_ready_i;
                out_d       = out_q;
                rd_ptr_d    = '0;
                rd_left_d   = held_q;
                wr_ptr_d    = '0;
                wr_left_d   = held_q;
                state_d     = S_SCAN;
              end
            end
            rrhb_pkg::CMD_SUM: begin
              if (held_q != '0) begin
                out_valid_d = out_valid_q && !res_ready_i;
                out_d       = out_q;
                total_d     = '0;
                rd_ptr_d    = '0;
                rd_left_d   = held_q;
                wr_ptr_d    = '0;
                wr_left_d   = held_q;
                state_d     = S_SCAN;
              end
            end
            rrhb_pkg::CMD_FLUSH: begin
              held_d          = '0;
              mod_d           = '0;
              out_d.row_count = '0;
            end
            default: begin
              out_d.status = rrhb_pkg::ST_OK;
            end
          endcase
        end
      end

      S_READ: begin
        out_valid_d     = 1'b1;
        out_d           = '0;
        out_d.row       = rdata_q;
        out_d.row_count = held_q;
        state_d         = S_IDLE;
      end

      S_SCAN, S_SHIFT: begin
        if (rd_left_q != '0) begin
          mem_re    = 1'b1;
          rd_ptr_d  = rd_ptr_q + 1'b1;
          rd_left_d = rd_left_q - 1'b1;
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          wr_ptr_d  = wr_ptr_q + 1'b1;
          wr_left_d = wr_left_q - 1'b1;
          if (state_q == S_SHIFT) begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_q[AW-1:0];
            mem_wdata = rdata_q;
            if (wr_left_q == CW'(1)) state_d = S_IDLE;
          end else begin
            out_d           = '0;
            out_d.row_count = held_q;
            if (op_q == rrhb_pkg::CMD_FIND) begin
              out_d.found = rrhb_pkg::NOT_FOUND;
              if (rdata_q == row_q) begin
                out_d.found = wr_ptr_q;
                out_valid_d = 1'b1;
                state_d     = S_IDLE;
              end else if (wr_left_q == CW'(1)) begin
                out_valid_d = 1'b1;
                state_d     = S_IDLE;
              end
            end else begin
              total_d     = tsum;
              out_d.total = tsum;
              if (wr_left_q == CW'(1)) begin
                out_valid_d = 1'b1;
                state_d     = S_IDLE;
              end
            end
            if (!out_valid_d) out_d = out_q;
          end
        end
      end

      S_MOD: begin
        // Rebuild the count modulo drop_at by repeated subtraction.
        if ((drop_q != '0) && (mod_q >= drop_q)) begin
          mod_d = mod_q - drop_q;
        end else begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      mod_q       <= '0;
      drop_q      <= '0;
      dirty_q     <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      mod_q       <= mod_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        drop_q  <= cfg_wdata_i;
        dirty_q <= 1'b1;
      end else begin
        dirty_q <= dirty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    row_q     <= row_d;
    col_q     <= col_d;
    rd_ptr_q  <= rd_ptr_d;
    rd_left_q <= rd_left_d;
    wr_ptr_q  <= wr_ptr_d;
    wr_left_q <= wr_left_d;
    total_q   <= total_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(rrhb_pkg::DEPTH))
    else $error("row count beyond depth");

  a_pop_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_valid_q || res_ready_i))
    else $error("request taken while result register busy");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !dirty_q && drop_q != '0) |-> (mod_q < drop_q))
    else $error("count residue out of range");

endmodule

// File: bench/tb_rolling_row_history_buffer.sv
// Self-checking bench for the rolling row history buffer: random and directed
// command streams, every result checked against a behavioral store model.
// Depends on rrhb_pkg and the RTL top level rolling_row_history_buffer.
`timescale 1ns / 100ps

module tb_rolling_row_history_buffer;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  found;
    logic [31:0] e0, e1, e2, e3;
    logic [37:0] total;
    logic [6:0]  count;
  } hist_res_t;

  class history_scoreboard;
    logic signed [31:0] rows[rrhb_pkg::DEPTH][rrhb_pkg::COLS];
    int unsigned        held;
    int unsigned        drop_at;
    hist_res_t          pending[$];
    int                 errors;

    function new();
      int r, k;
      for (r = 0; r < rrhb_pkg::DEPTH; r++)
        for (k = 0; k < rrhb_pkg::COLS; k++) rows[r][k] = '0;
      held = 0; drop_at = 0; errors = 0;
    endfunction

    function void clear_rows();
      int r, k;
      for (r = 0; r < rrhb_pkg::DEPTH; r++)
        for (k = 0; k < rrhb_pkg::COLS; k++) rows[r][k] = '0;
    endfunction

    // remove n rows starting at first, shifting the rest down
    function void remove_rows(int unsigned first, int unsigned n);
      int unsigned r;
      int k;
      for (r = first; r + n < held; r++)
        for (k = 0; k < rrhb_pkg::COLS; k++) rows[r][k] = rows[r + n][k];
      for (r = held - n; r < held; r++)
        for (k = 0; k < rrhb_pkg::COLS; k++) rows[r][k] = '0;
      held = held - n;
    endfunction

    function logic [1:0] locate(logic [6:0] sel, output int unsigned row);
      int s, idx;
      row = 0;
      if (held == 0) return rrhb_pkg::ST_EMPTY;
      s = $signed(sel);
      idx = (s < 0) ? int'(held) + s : s;
      if (idx < 0 || idx >= int'(held)) return rrhb_pkg::ST_RANGE;
      row = idx;
      return rrhb_pkg::ST_OK;
    endfunction

    function void note_request(logic [143:0] d);
      logic [2:0] cmd;
      logic [6:0] sel;
      logic [2:0] cnt;
      logic [1:0] col;
      logic signed [31:0] e[4];
      hist_res_t res;
      int unsigned row, r;
      int k;
      bit eq;
      logic [37:0] acc;
      cmd = d[2:0]; sel = d[9:3]; cnt = d[12:10];
      e[0] = d[44:13]; e[1] = d[76:45]; e[2] = d[108:77]; e[3] = d[140:109];
      col = d[142:141];
      res = '0;
      case (cmd)
        rrhb_pkg::CMD_APPEND: begin
          if (held >= rrhb_pkg::DEPTH) res.status = rrhb_pkg::ST_FULL;
          else begin
            for (k = 0; k < rrhb_pkg::COLS; k++) rows[held][k] = (k < cnt) ? e[k] : '0;
            held++;
            if (drop_at != 0 && held % drop_at == 0 && drop_at / 2 != 0) begin
              if (drop_at / 2 >= held) begin
                clear_rows(); held = 0;
              end else remove_rows(0, drop_at / 2);
            end
          end
        end
        rrhb_pkg::CMD_READ: begin
          res.status = locate(sel, row);
          if (res.status == rrhb_pkg::ST_OK) begin
            res.e0 = rows[row][0]; res.e1 = rows[row][1];
            res.e2 = rows[row][2]; res.e3 = rows[row][3];
          end
        end
        rrhb_pkg::CMD_DELETE: begin
          res.status = locate(sel, row);
          if (res.status == rrhb_pkg::ST_OK) remove_rows(row, 1);
        end
        rrhb_pkg::CMD_FIND: begin
          res.found = rrhb_pkg::NOT_FOUND;
          if (held == 0) res.status = rrhb_pkg::ST_EMPTY;
          else if (cnt == rrhb_pkg::COLS) begin
            for (r = 0; r < held; r++) begin
              eq = 1;
              for (k = 0; k < rrhb_pkg::COLS; k++) if (rows[r][k] != e[k]) eq = 0;
              if (eq) begin
                res.found = r[6:0];
                break;
              end
            end
          end
        end
        rrhb_pkg::CMD_SUM: begin
          acc = '0;
          for (r = 0; r < held; r++) acc = acc + {{6{rows[r][col][31]}}, rows[r][col]};
          res.total = acc;
        end
        rrhb_pkg::CMD_FLUSH: begin
          clear_rows(); held = 0;
        end
        default: ;
      endcase
      res.count = held[6:0];
      pending.push_back(res);
    endfunction

    function void check_result(logic [183:0] d);
      hist_res_t exp_r, got;
      got.status = d[1:0];   got.found = d[8:2];
      got.e0 = d[40:9];      got.e1 = d[72:41];
      got.e2 = d[104:73];    got.e3 = d[136:105];
      got.total = d[174:137]; got.count = d[181:175];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r || d[183:182] !== 2'b00) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d fi=%h e=%h %h %h %h tot=%h cnt=%0d", exp_r.status,
                   exp_r.found, exp_r.e0, exp_r.e1, exp_r.e2, exp_r.e3, exp_r.total,
                   exp_r.count, "\n          got st=%0d fi=%h e=%h %h %h %h tot=%h cnt=%0d",
                   got.status, got.found, got.e0, got.e1, got.e2, got.e3, got.total,
                   got.count);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [6:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [183:0] m_axis_tdata;

  history_scoreboard sb = new();
  int unsigned cycles = 0;
  bit          calm = 0;       // no idling in the last part
  bit          hold_sink = 0;  // long receiver hold-off
  logic signed [31:0] pool[8];

  rolling_row_history_buffer u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // receiver: random stall bursts, or held off entirely
  initial begin : sink
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 0;
        @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        m_axis_tready <= 0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1;
        n = $urandom_range(1, 30);
        repeat (n) begin
          if (hold_sink) break;
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send(input logic [143:0] d);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 18);
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);  // delete or drop shifts may still run
  endtask

  task automatic set_drop(input logic [6:0] v);
    drain();
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.drop_at = v;
  endtask

  function automatic logic [143:0] pack_req(logic [2:0] cmd, logic [6:0] sel,
      logic [2:0] cnt, logic [31:0] a, logic [31:0] b, logic [31:0] c,
      logic [31:0] e, logic [1:0] col);
    return {1'b0, col, e, c, b, a, cnt, sel, cmd};
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return pool[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [143:0] rand_req();
    logic [2:0] cmd;
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) cmd = rrhb_pkg::CMD_APPEND;
    else if (p < 65) cmd = rrhb_pkg::CMD_READ;
    else if (p < 75) cmd = rrhb_pkg::CMD_DELETE;
    else if (p < 87) cmd = rrhb_pkg::CMD_FIND;
    else if (p < 96) cmd = rrhb_pkg::CMD_SUM;
    else if (p < 98) cmd = rrhb_pkg::CMD_FLUSH;
    else cmd = 3'($urandom_range(6, 7));
    return pack_req(cmd, 7'($urandom), 3'($urandom_range(0, 7)) | (p[0] ? 3'd4 : 3'd0),
                    rand_elem(), rand_elem(), rand_elem(), rand_elem(), 2'($urandom));
  endfunction

  initial begin : main
    int i, k;
    int drops[6];
    drops = '{0, 1, 64, 2, 7, 13};
    for (k = 0; k < 8; k++) pool[k] = $urandom_range(0, 3);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty store cases, extremes, every command
    send(pack_req(rrhb_pkg::CMD_READ, 7'd0, 3'd4, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_DELETE, 7'h7F, 3'd4, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_FIND, 7'd0, 3'd4, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_SUM, 7'd0, 3'd0, '0, '0, '0, '0, 2'd3));
    send(pack_req(rrhb_pkg::CMD_APPEND, 7'd0, 3'd4, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'h0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_APPEND, 7'd0, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'd1, 32'd2, 2'd0));
    send(pack_req(rrhb_pkg::CMD_APPEND, 7'd0, 3'd2, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'd1, 32'd2, 2'd1));
    send(pack_req(rrhb_pkg::CMD_APPEND, 7'd0, 3'd0, 32'hFFFF_FFFF, 32'd5, 32'd6, 32'd7,
                  2'd2));
    send(pack_req(rrhb_pkg::CMD_READ, 7'h40, 3'd0, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_READ, 7'h7F, 3'd0, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_READ, 7'h7C, 3'd0, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_READ, 7'd63, 3'd0, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_FIND, 7'd0, 3'd4, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'd1, 32'd2, 2'd0));
    send(pack_req(rrhb_pkg::CMD_FIND, 7'd0, 3'd3, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'd1, 32'd2, 2'd0));
    send(pack_req(rrhb_pkg::CMD_FIND, 7'd0, 3'd4, 32'd9, 32'd9, 32'd9, 32'd9, 2'd0));
    for (k = 0; k < 4; k++)
      send(pack_req(rrhb_pkg::CMD_SUM, 7'd0, 3'd0, '0, '0, '0, '0, 2'(k)));
    send(pack_req(rrhb_pkg::CMD_DELETE, 7'd1, 3'd0, '0, '0, '0, '0, 2'd0));
    send(pack_req(rrhb_pkg::CMD_DELETE, 7'h3F, 3'd0, '0, '0, '0, '0, 2'd0));
    send(pack_req(3'd6, 7'd0, 3'd0, '0, '0, '0, '0, 2'd0));
    send(pack_req(3'd7, 7'h7F, 3'd7, '1, '1, '1, '1, 2'd3));
    send(pack_req(rrhb_pkg::CMD_FLUSH, 7'd0, 3'd0, '0, '0, '0, '0, 2'd0));

    // fill to full, then append once more for the full status
    for (i = 0; i < rrhb_pkg::DEPTH + 1; i++)
      send(pack_req(rrhb_pkg::CMD_APPEND, 7'd0, 3'd4, 32'($urandom_range(0, 2)) - 32'sd1,
                    $urandom, 32'h8000_0000, 32'h7FFF_FFFF, 2'd0));
    for (k = 0; k < 4; k++)
      send(pack_req(rrhb_pkg::CMD_SUM, 7'd0, 3'd0, '0, '0, '0, '0, 2'(k)));

    // receiver holds off while the sender keeps offering
    hold_sink = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
      end
      for (i = 0; i < 12; i++) send(rand_req());
    join

    // random phases over several drop settings
    for (k = 0; k < 6; k++) begin
      set_drop(drops[k]);
      if (k == 5) calm = 1;
      for (i = 0; i < 50; i++) send(rand_req());
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: files.f
rtl/rrhb_pkg.sv
rtl/rrhb_front.sv
rtl/rrhb_back.sv
rtl/rolling_row_history_buffer.sv
bench/tb_rolling_row_history_buffer.sv
